[rtl/core/cdo_pkg.sv]
package cdo_pkg;

	// field widths
	localparam int OFFSET_BITS = 17;
	localparam int YEAR_W      = 14;
	localparam int MONTH_W     = 4;
	localparam int DAY_W       = 5;
	localparam int ERR_W       = 2;

	// stream packing, first field lowest
	localparam int IN_YEAR_LSB  = 0;
	localparam int IN_MONTH_LSB = IN_YEAR_LSB + YEAR_W;
	localparam int IN_DAY_LSB   = IN_MONTH_LSB + MONTH_W;
	localparam int IN_OFF_LSB   = IN_DAY_LSB + DAY_W;
	localparam int IN_W         = IN_OFF_LSB + OFFSET_BITS;
	localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W        = YEAR_W + MONTH_W + DAY_W;
	localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W  = 8;

	// working widths
	localparam int ACC_W  = OFFSET_BITS + 2;  // signed day accumulator
	localparam int YACC_W = YEAR_W + 3;       // signed running year
	localparam int RES_W  = 9;                // year within the 400-year cycle
	localparam int YLEN_W = 9;

	localparam int YEAR_MAX    = 9999;
	localparam int CYCLE_YEARS = 400;
	localparam int BIG_STRIDE  = 3200;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_MONTH = 2'd1;
	localparam logic [ERR_W-1:0] ERR_YEAR  = 2'd2;

	// microcode fields
	localparam int STEP_W = 4;
	localparam int OP_W   = 4;
	localparam int COND_W = 4;

	localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 4'd1;
	localparam logic [OP_W-1:0] OP_SUB_BIG = 4'd2;
	localparam logic [OP_W-1:0] OP_SUB_CYC = 4'd3;
	localparam logic [OP_W-1:0] OP_FMON    = 4'd4;
	localparam logic [OP_W-1:0] OP_FYEAR   = 4'd5;
	localparam logic [OP_W-1:0] OP_BMON    = 4'd6;
	localparam logic [OP_W-1:0] OP_BYEAR   = 4'd7;
	localparam logic [OP_W-1:0] OP_DONE    = 4'd8;

	localparam logic [COND_W-1:0] C_ALWAYS  = 4'd0;
	localparam logic [COND_W-1:0] C_START   = 4'd1;
	localparam logic [COND_W-1:0] C_MBAD    = 4'd2;
	localparam logic [COND_W-1:0] C_RGE_BIG = 4'd3;
	localparam logic [COND_W-1:0] C_RGE_CYC = 4'd4;
	localparam logic [COND_W-1:0] C_FMON1   = 4'd5;
	localparam logic [COND_W-1:0] C_FYEAR   = 4'd6;
	localparam logic [COND_W-1:0] C_FMON    = 4'd7;
	localparam logic [COND_W-1:0] C_BMON1   = 4'd8;
	localparam logic [COND_W-1:0] C_BYEAR   = 4'd9;
	localparam logic [COND_W-1:0] C_BMON    = 4'd10;

	// program steps
	localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
	localparam logic [STEP_W-1:0] STEP_CHECK    = 4'd1;
	localparam logic [STEP_W-1:0] STEP_RED_BIG  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_RED_CYC  = 4'd3;
	localparam logic [STEP_W-1:0] STEP_FWD_MON1 = 4'd4;
	localparam logic [STEP_W-1:0] STEP_FWD_YEAR = 4'd5;
	localparam logic [STEP_W-1:0] STEP_FWD_MON  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_BWD_MON1 = 4'd7;
	localparam logic [STEP_W-1:0] STEP_BWD_YEAR = 4'd8;
	localparam logic [STEP_W-1:0] STEP_BWD_MON  = 4'd9;
	localparam logic [STEP_W-1:0] STEP_DONE     = 4'd10;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
		logic              stay;   // hold the step while the condition is false
	} ucode_t;

	// leap test on the year's place in the 400-year cycle
	function automatic logic is_leap(input logic [RES_W-1:0] r);
		return (r[1:0] == 2'b00) && (r != RES_W'(100)) && (r != RES_W'(200))
			&& (r != RES_W'(300));
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] n;
		case (m)
			4'd2:    n = leap ? 5'd29 : 5'd28;
			4'd4:    n = 5'd30;
			4'd6:    n = 5'd30;
			4'd9:    n = 5'd30;
			4'd11:   n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

	function automatic logic [YLEN_W-1:0] year_days(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

endpackage

[rtl/core/cdo_ucode_rom.sv]
module cdo_ucode_rom
	import cdo_pkg::*;
(
	input  logic [STEP_W-1:0] step,
	output ucode_t            cw
);

	// on a true condition: run op, go to target; otherwise next step (or stay)
	always_comb begin
		case (step)
			STEP_IDLE:     cw = '{op: OP_LOAD,    cond: C_START,   target: STEP_CHECK,    stay: 1'b1};
			STEP_CHECK:    cw = '{op: OP_NOP,     cond: C_MBAD,    target: STEP_DONE,     stay: 1'b0};
			STEP_RED_BIG:  cw = '{op: OP_SUB_BIG, cond: C_RGE_BIG, target: STEP_RED_BIG,  stay: 1'b0};
			STEP_RED_CYC:  cw = '{op: OP_SUB_CYC, cond: C_RGE_CYC, target: STEP_RED_CYC,  stay: 1'b0};
			STEP_FWD_MON1: cw = '{op: OP_FMON,    cond: C_FMON1,   target: STEP_FWD_MON1, stay: 1'b0};
			STEP_FWD_YEAR: cw = '{op: OP_FYEAR,   cond: C_FYEAR,   target: STEP_FWD_YEAR, stay: 1'b0};
			STEP_FWD_MON:  cw = '{op: OP_FMON,    cond: C_FMON,    target: STEP_FWD_MON,  stay: 1'b0};
			STEP_BWD_MON1: cw = '{op: OP_BMON,    cond: C_BMON1,   target: STEP_BWD_MON1, stay: 1'b0};
			STEP_BWD_YEAR: cw = '{op: OP_BYEAR,   cond: C_BYEAR,   target: STEP_BWD_YEAR, stay: 1'b0};
			STEP_BWD_MON:  cw = '{op: OP_BMON,    cond: C_BMON,    target: STEP_BWD_MON,  stay: 1'b0};
			STEP_DONE:     cw = '{op: OP_DONE,    cond: C_ALWAYS,  target: STEP_IDLE,     stay: 1'b0};
			default:       cw = '{op: OP_NOP,     cond: C_ALWAYS,  target: STEP_IDLE,     stay: 1'b0};
		endcase
	end

endmodule

[rtl/core/calendar_date_offset.sv]
// calendar_date_offset: gregorian date plus a signed day offset
//
// input stream (s_axis): one word per request holding start year, month, day and
// the two's complement day offset. output stream (m_axis): one word per request
// with the normalised date, the error code travelling in tuser.
// a small microcoded sequencer walks the day count through the calendar: first
// it reduces the year modulo 400 (for the leap test), then steps single months
// up to january, whole years (one year per cycle), then single months again;
// a negative count walks backwards the same way.
// a bad month goes from the check step straight to the final step; a valid date
// also passes through every reduction and walking step, and takes longer with each
// residue subtraction (up to 11), each single month (up to 23) and each whole year
// (about |offset| / 365).
// one request is worked on at a time: s_axis_tready is high only while the
// sequencer is idle, and the next word is taken as soon as the result has been
// moved to the output register, even if that result is still waiting.
// if the receiver stalls, the result holds in the output register and the
// sequencer waits at its final step until the register is free.
// reset (arst_n low) returns the sequencer to idle and drops m_axis_tvalid.
module calendar_date_offset
	import cdo_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// start_year[13:0], start_month[17:14], start_day[22:18], offset_days[39:23]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// result_year[13:0], result_month[17:14], result_day[22:18], zero pad above
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// error_code[1:0], zero pad above
	output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	// sequencer
	logic [STEP_W-1:0] step_q;
	ucode_t            cw;

	// working registers
	logic signed [ACC_W-1:0]  d_q;   // running day count
	logic signed [YACC_W-1:0] y_q;   // running year
	logic [MONTH_W-1:0]       m_q;   // running month
	logic [YEAR_W-1:0]        r_q;   // year modulo 400 once reduced
	logic [YEAR_W-1:0]        ey_q;  // echo of the input date
	logic [MONTH_W-1:0]       em_q;
	logic [DAY_W-1:0]         ed_q;

	// output register
	logic               out_valid_q;
	logic [YEAR_W-1:0]  out_year_q;
	logic [MONTH_W-1:0] out_month_q;
	logic [DAY_W-1:0]   out_day_q;
	logic [ERR_W-1:0]   out_err_q;

	// input word fields
	logic [YEAR_W-1:0]      in_year;
	logic [MONTH_W-1:0]     in_month;
	logic [DAY_W-1:0]       in_day;
	logic [OFFSET_BITS-1:0] in_off;

	assign in_year  = s_axis_tdata[IN_YEAR_LSB +: YEAR_W];
	assign in_month = s_axis_tdata[IN_MONTH_LSB +: MONTH_W];
	assign in_day   = s_axis_tdata[IN_DAY_LSB +: DAY_W];
	assign in_off   = s_axis_tdata[IN_OFF_LSB +: OFFSET_BITS];

	cdo_ucode_rom u_rom (
		.step (step_q),
		.cw   (cw)
	);

	// calendar datapath terms
	logic [RES_W-1:0]        r_lo, r_inc, r_dec;
	logic                    leap_cur, leap_prev, m_is_jan, m_is_dec, mbad;
	logic [MONTH_W-1:0]      m_back;
	logic [DAY_W-1:0]        mlen_cur, mlen_back;
	logic [YLEN_W-1:0]       ylen_cur, ylen_prev;
	logic signed [ACC_W-1:0] mlen_cur_s, mlen_back_s, ylen_cur_s, ylen_prev_s;
	logic signed [ACC_W-1:0] d_back_year;
	logic                    d_gt_mlen, d_le0, back_year_le0, y_out_range;

	assign r_lo     = r_q[RES_W-1:0];
	assign r_inc    = (r_lo == RES_W'(CYCLE_YEARS - 1)) ? '0 : r_lo + 1'b1;
	assign r_dec    = (r_lo == '0) ? RES_W'(CYCLE_YEARS - 1) : r_lo - 1'b1;
	assign leap_cur  = is_leap(r_lo);
	assign leap_prev = is_leap(r_dec);

	assign m_is_jan = (m_q == 4'd1);
	assign m_is_dec = (m_q == 4'd12);
	assign mbad     = (m_q == 4'd0) || (m_q > 4'd12);
	assign m_back   = m_is_jan ? 4'd12 : m_q - 1'b1;

	assign mlen_cur  = month_days(m_q, leap_cur);
	assign mlen_back = month_days(m_back, m_is_jan ? leap_prev : leap_cur);
	assign ylen_cur  = year_days(leap_cur);
	assign ylen_prev = year_days(leap_prev);

	assign mlen_cur_s  = $signed({{(ACC_W - DAY_W){1'b0}}, mlen_cur});
	assign mlen_back_s = $signed({{(ACC_W - DAY_W){1'b0}}, mlen_back});
	assign ylen_cur_s  = $signed({{(ACC_W - YLEN_W){1'b0}}, ylen_cur});
	assign ylen_prev_s = $signed({{(ACC_W - YLEN_W){1'b0}}, ylen_prev});

	assign d_back_year   = d_q + ylen_prev_s;
	assign d_le0         = d_q[ACC_W-1] || (d_q == '0);
	assign back_year_le0 = d_back_year[ACC_W-1] || (d_back_year == '0);
	assign d_gt_mlen     = d_q > mlen_cur_s;
	assign y_out_range   = y_q[YACC_W-1] || (y_q > $signed(YACC_W'(YEAR_MAX)));

	// jump condition
	logic cond_true, out_block, fire;

	always_comb begin
		case (cw.cond)
			C_ALWAYS:  cond_true = 1'b1;
			C_START:   cond_true = s_axis_tvalid;
			C_MBAD:    cond_true = mbad;
			C_RGE_BIG: cond_true = r_q >= YEAR_W'(BIG_STRIDE);
			C_RGE_CYC: cond_true = r_q >= YEAR_W'(CYCLE_YEARS);
			C_FMON1:   cond_true = !m_is_jan && d_gt_mlen;
			C_FYEAR:   cond_true = m_is_jan && (d_q > ylen_cur_s);
			C_FMON:    cond_true = d_gt_mlen;
			C_BMON1:   cond_true = !m_is_jan && d_le0;
			C_BYEAR:   cond_true = m_is_jan && d_le0 && back_year_le0;
			C_BMON:    cond_true = d_le0;
			default:   cond_true = 1'b0;
		endcase
	end

	// the final step waits while the output register holds a word that is not being taken
	assign out_block = (cw.op == OP_DONE) && out_valid_q && !m_axis_tready;
	assign fire      = cond_true && !out_block;

	assign s_axis_tready = (step_q == STEP_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else if (fire) begin
			step_q <= cw.target;
		end else if (!cw.stay && !out_block) begin
			step_q <= step_q + 1'b1;
		end
	end

	// datapath, one operation per fired step
	always_ff @(posedge clk) begin
		if (fire) begin
			case (cw.op)
				OP_LOAD: begin
					y_q  <= $signed({{(YACC_W - YEAR_W){1'b0}}, in_year});
					m_q  <= in_month;
					d_q  <= $signed({{(ACC_W - DAY_W){1'b0}}, in_day})
						+ $signed({{(ACC_W - OFFSET_BITS){in_off[OFFSET_BITS-1]}}, in_off});
					r_q  <= in_year;
					ey_q <= in_year;
					em_q <= in_month;
					ed_q <= in_day;
				end
				OP_SUB_BIG: r_q <= r_q - YEAR_W'(BIG_STRIDE);
				OP_SUB_CYC: r_q <= r_q - YEAR_W'(CYCLE_YEARS);
				OP_FMON: begin
					d_q <= d_q - mlen_cur_s;
					if (m_is_dec) begin
						m_q <= 4'd1;
						y_q <= y_q + 1'b1;
						r_q <= YEAR_W'(r_inc);
					end else begin
						m_q <= m_q + 1'b1;
					end
				end
				OP_FYEAR: begin
					d_q <= d_q - ylen_cur_s;
					y_q <= y_q + 1'b1;
					r_q <= YEAR_W'(r_inc);
				end
				OP_BMON: begin
					d_q <= d_q + mlen_back_s;
					m_q <= m_back;
					if (m_is_jan) begin
						y_q <= y_q - 1'b1;
						r_q <= YEAR_W'(r_dec);
					end
				end
				OP_BYEAR: begin
					d_q <= d_back_year;
					y_q <= y_q - 1'b1;
					r_q <= YEAR_W'(r_dec);
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && (cw.op == OP_DONE)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (cw.op == OP_DONE)) begin
			if (mbad || y_out_range) begin
				// echo the input date on either error
				out_year_q  <= ey_q;
				out_month_q <= em_q;
				out_day_q   <= ed_q;
				out_err_q   <= mbad ? ERR_MONTH : ERR_YEAR;
			end else begin
				out_year_q  <= y_q[YEAR_W-1:0];
				out_month_q <= m_q;
				out_day_q   <= d_q[DAY_W-1:0];
				out_err_q   <= ERR_OK;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_day_q, out_month_q, out_year_q};
	assign m_axis_tuser  = {{(OUT_TUSER_W - ERR_W){1'b0}}, out_err_q};

	// checks

	// the cycle residue is reduced before any calendar step uses it
	a_residue_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q >= STEP_FWD_MON1 && step_q < STEP_DONE) |-> (r_q < YEAR_W'(CYCLE_YEARS)))
		else $error("year residue not reduced below 400");

	// a valid date reaches the final step with a day inside the month
	a_day_normalised: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_DONE && !mbad) |-> (!d_le0 && !d_gt_mlen))
		else $error("day count not normalised at the final step");

	// a result reported as ok carries a real calendar date
	a_ok_is_date: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q == ERR_OK)
			|-> (out_month_q >= 4'd1 && out_month_q <= 4'd12 && out_day_q != '0))
		else $error("ok result with an impossible date");

endmodule
